@@ hdl/assert_macros.svh @@
// Assertion macros shared by the frame receiver RTL.
// No dependencies; SYNTH selects the empty forms for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked while out of reset.
`define CRSF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("crsf receiver assertion failed");
// Checked at every edge, reset included.
`define CRSF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("crsf receiver assertion failed");
`else
`define CRSF_ASSERT(lbl, prop)
`define CRSF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ hdl/crsf_pkg.sv @@
// Types, constants and the CRC-8 step for the frame receiver.
// No dependencies.
`timescale 1ns / 1ps
package crsf_pkg;

  localparam int PAYLOAD_DEPTH    = 64;
  localparam int FRAME_BYTE_LIMIT = 64;
  localparam int CHANNEL_COUNT    = 16;
  localparam int CHANNEL_BITS     = 11;

  localparam int ADDR_W   = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W    = $clog2(FRAME_BYTE_LIMIT + 2);
  localparam int SEEN_W   = $clog2(FRAME_BYTE_LIMIT);
  localparam int EXP_W    = 7;
  localparam int BITPOS_W = $clog2(CHANNEL_COUNT * CHANNEL_BITS) + 1;
  localparam int BIDX_W   = BITPOS_W - 2;
  localparam int WIN_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [7:0] CRC_POLY         = 8'hD5;
  localparam logic [7:0] LINK_STATS_TYPE  = 8'h14;
  localparam logic [7:0] DEVICE_INFO_TYPE = 8'h29;

  localparam logic [7:0] SYNC_A_RST     = 8'd238;
  localparam logic [7:0] SYNC_B_RST     = 8'd234;
  localparam logic [7:0] SYNC_C_RST     = 8'd200;
  localparam logic [7:0] SYNC_D_RST     = 8'd236;
  localparam logic [6:0] LEN_LIMIT_RST  = 7'd64;
  localparam logic [7:0] TYPE_LIMIT_RST = 8'h7D;
  localparam logic [7:0] CHAN_TYPE_RST  = 8'd22;

  typedef enum logic [2:0] {
    REG_SYNC_A     = 3'd0,
    REG_SYNC_B     = 3'd1,
    REG_SYNC_C     = 3'd2,
    REG_SYNC_D     = 3'd3,
    REG_LEN_LIMIT  = 3'd4,
    REG_TYPE_LIMIT = 3'd5,
    REG_CHAN_TYPE  = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SYNC_ERR  = 3'd1,
    ST_LEN_ERR   = 3'd2,
    ST_TYPE_ERR  = 3'd3,
    ST_CRC_ERR   = 3'd4,
    ST_UNHANDLED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_SYNC, PH_LEN, PH_TYPE, PH_PAYLOAD, PH_CRC
  } phase_t;

  typedef enum logic {
    CTL_RUN, CTL_UNPACK
  } ctl_state_t;

  typedef enum logic [2:0] {
    UP_IDLE, UP_RD0, UP_RD1, UP_RD2, UP_RD3, UP_OUT
  } unp_state_t;

  typedef struct packed {
    logic [7:0] sync_a;
    logic [7:0] sync_b;
    logic [7:0] sync_c;
    logic [7:0] sync_d;
    logic [6:0] length_limit;
    logic [7:0] type_limit;
    logic [7:0] chan_type;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [SEEN_W-1:0] seen;
  } unp_req_t;

  typedef struct packed {
    logic        busy;
    logic        valid;
    logic [3:0]  index;
    logic [10:0] value;
    logic        last;
  } unp_rsp_t;

  // CRC-8, MSB first, one byte.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ hdl/crsf_if.sv @@
// Valid/ready channel interfaces: received bytes in, results out.
// Depends on nothing.
`timescale 1ns / 1ps
interface crsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crsf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  frame_kind;
  logic        channel_valid;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic [15:0] error_total;
  logic        last;
  modport source (output valid, output status, output frame_kind, output channel_valid,
                  output channel_index, output channel_value, output error_total,
                  output last, input ready);
  modport sink   (input valid, input status, input frame_kind, input channel_valid,
                  input channel_index, input channel_value, input error_total,
                  input last, output ready);
endinterface

@@ hdl/crsf_ram.sv @@
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module crsf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/crsf_unpack.sv @@
// Channel unpacker: reads three payload bytes per channel from the RAM
// and extracts the LSB-first channel field. Depends on crsf_pkg.
`timescale 1ns / 1ps
module crsf_unpack (
  input  logic                           clk,
  input  logic                           rst_n,
  input  crsf_pkg::unp_req_t             req,
  output crsf_pkg::unp_rsp_t             rsp,
  input  logic                           rsp_ready,
  output logic [crsf_pkg::ADDR_W-1:0]    raddr,
  input  logic [7:0]                     rdata
);

  crsf_pkg::unp_state_t st_r, st_nxt;
  logic [3:0]                      ch_r, ch_nxt;
  logic [crsf_pkg::BITPOS_W-1:0]   pos_r, pos_nxt;
  logic [crsf_pkg::SEEN_W-1:0]     seen_r, seen_nxt;
  logic [crsf_pkg::WIN_W-1:0]      win_r, win_nxt;

  logic [crsf_pkg::BIDX_W-1:0]     bidx, rd_idx, cap_idx;
  logic [1:0]                      rd_off, cap_off;
  logic                            cap_ok;
  logic [7:0]                      cap_byte;
  logic [crsf_pkg::WIN_W-1:0]      shifted;
  logic [crsf_pkg::CHANNEL_BITS-1:0] chan_bits;
  logic                            is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= crsf_pkg::UP_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    ch_r   <= ch_nxt;
    pos_r  <= pos_nxt;
    seen_r <= seen_nxt;
    win_r  <= win_nxt;
  end

  assign bidx    = crsf_pkg::BIDX_W'(pos_r >> 3);
  assign rd_idx  = bidx + crsf_pkg::BIDX_W'(rd_off);
  assign cap_idx = bidx + crsf_pkg::BIDX_W'(cap_off);
  assign raddr   = crsf_pkg::ADDR_W'(rd_idx);
  // bytes past the received payload read as zero
  assign cap_ok  = (32'(cap_idx) < 32'(seen_r)) && (32'(cap_idx) < crsf_pkg::PAYLOAD_DEPTH);
  assign cap_byte = cap_ok ? rdata : 8'h00;

  assign shifted   = win_r >> pos_r[2:0];
  assign chan_bits = crsf_pkg::CHANNEL_BITS'(shifted);
  assign is_last   = (ch_r == 4'(crsf_pkg::CHANNEL_COUNT - 1));

  always_comb begin
    st_nxt   = st_r;
    ch_nxt   = ch_r;
    pos_nxt  = pos_r;
    seen_nxt = seen_r;
    win_nxt  = win_r;
    rd_off   = 2'd0;
    cap_off  = 2'd0;
    unique case (st_r)
      crsf_pkg::UP_IDLE: begin
        if (req.start) begin
          ch_nxt   = '0;
          pos_nxt  = '0;
          seen_nxt = req.seen;
          st_nxt   = crsf_pkg::UP_RD0;
        end
      end
      crsf_pkg::UP_RD0: begin
        rd_off = 2'd0;
        st_nxt = crsf_pkg::UP_RD1;
      end
      crsf_pkg::UP_RD1: begin
        rd_off = 2'd1;
        cap_off = 2'd0;
        win_nxt[7:0] = cap_byte;
        st_nxt = crsf_pkg::UP_RD2;
      end
      crsf_pkg::UP_RD2: begin
        rd_off = 2'd2;
        cap_off = 2'd1;
        win_nxt[15:8] = cap_byte;
        st_nxt = crsf_pkg::UP_RD3;
      end
      crsf_pkg::UP_RD3: begin
        cap_off = 2'd2;
        win_nxt[23:16] = cap_byte;
        st_nxt = crsf_pkg::UP_OUT;
      end
      crsf_pkg::UP_OUT: begin
        if (rsp_ready) begin
          if (is_last) begin
            st_nxt = crsf_pkg::UP_IDLE;
          end else begin
            ch_nxt  = ch_r + 4'd1;
            pos_nxt = pos_r + crsf_pkg::BITPOS_W'(crsf_pkg::CHANNEL_BITS);
            st_nxt  = crsf_pkg::UP_RD0;
          end
        end
      end
      default: begin
        st_nxt = crsf_pkg::UP_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp.busy  = (st_r != crsf_pkg::UP_IDLE);
    rsp.valid = (st_r == crsf_pkg::UP_OUT);
    rsp.index = ch_r;
    rsp.value = 11'(chan_bits);
    rsp.last  = is_last;
  end

endmodule

@@ hdl/crsf_frame_fsm.sv @@
// Byte parser: frame phases, CRC, error counter, payload writes and the
// result register. Depends on crsf_pkg and crsf_if.
`timescale 1ns / 1ps
module crsf_frame_fsm (
  input  logic                        clk,
  input  logic                        rst_n,
  crsf_in_if.sink                     in_bus,
  crsf_out_if.source                  out_bus,
  input  crsf_pkg::cfg_t              cfg,
  output logic                        ram_we,
  output logic [crsf_pkg::ADDR_W-1:0] ram_waddr,
  output logic [7:0]                  ram_wdata,
  output crsf_pkg::unp_req_t          unp_req,
  input  crsf_pkg::unp_rsp_t          unp_rsp,
  output logic                        unp_ready
);

  crsf_pkg::ctl_state_t ctl_r, ctl_nxt;
  crsf_pkg::phase_t     phase_r, phase_nxt;
  logic [crsf_pkg::EXP_W-1:0]  exp_r, exp_nxt;
  logic [crsf_pkg::SEEN_W-1:0] seen_r, seen_nxt;
  logic [crsf_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] err_r, err_nxt;

  logic        out_valid_r, out_valid_nxt;
  crsf_pkg::status_t out_status_r, out_status_nxt;
  logic [7:0]  out_kind_r, out_kind_nxt;
  logic        out_cvalid_r, out_cvalid_nxt;
  logic [3:0]  out_cidx_r, out_cidx_nxt;
  logic [10:0] out_cval_r, out_cval_nxt;
  logic [15:0] out_err_r, out_err_nxt;
  logic        out_last_r, out_last_nxt;

  logic        out_free, in_acc, long_frame, sync_hit;
  logic [crsf_pkg::CNT_W-1:0] cnt_inc;
  logic [15:0] err_sat;
  logic [7:0]  b;
  crsf_pkg::phase_t ph;
  logic        emit;
  crsf_pkg::status_t em_status;
  logic [7:0]  em_kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= crsf_pkg::CTL_RUN;
      phase_r     <= crsf_pkg::PH_SYNC;
      exp_r       <= '0;
      seen_r      <= '0;
      cnt_r       <= '0;
      type_r      <= '0;
      crc_r       <= '0;
      err_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      phase_r     <= phase_nxt;
      exp_r       <= exp_nxt;
      seen_r      <= seen_nxt;
      cnt_r       <= cnt_nxt;
      type_r      <= type_nxt;
      crc_r       <= crc_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_kind_r   <= out_kind_nxt;
    out_cvalid_r <= out_cvalid_nxt;
    out_cidx_r   <= out_cidx_nxt;
    out_cval_r   <= out_cval_nxt;
    out_err_r    <= out_err_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_free     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = (ctl_r == crsf_pkg::CTL_RUN) && out_free;
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign b            = in_bus.rx_byte;
  assign cnt_inc      = cnt_r + 1'b1;
  assign long_frame   = (32'(cnt_inc) > crsf_pkg::FRAME_BYTE_LIMIT);
  assign ph           = long_frame ? crsf_pkg::PH_SYNC : phase_r;
  assign err_sat      = (err_r == 16'hFFFF) ? err_r : err_r + 16'd1;
  assign sync_hit     = (b == cfg.sync_a) || (b == cfg.sync_b) ||
                        (b == cfg.sync_c) || (b == cfg.sync_d);

  // parser
  always_comb begin
    ctl_nxt   = ctl_r;
    phase_nxt = phase_r;
    exp_nxt   = exp_r;
    seen_nxt  = seen_r;
    cnt_nxt   = cnt_r;
    type_nxt  = type_r;
    crc_nxt   = crc_r;
    err_nxt   = err_r;
    emit      = 1'b0;
    em_status = crsf_pkg::ST_OK;
    em_kind   = 8'h00;
    ram_we    = 1'b0;
    ram_waddr = crsf_pkg::ADDR_W'(seen_r);
    ram_wdata = b;
    unp_req.start = 1'b0;
    unp_req.seen  = seen_r;
    unp_ready = 1'b0;
    unique case (ctl_r)
      crsf_pkg::CTL_RUN: begin
        if (in_acc) begin
          // overlong frame: drop it and treat this byte as a sync byte
          if (long_frame) begin
            seen_nxt = '0;
            exp_nxt  = '0;
            cnt_nxt  = '0;
          end else begin
            cnt_nxt  = cnt_inc;
          end
          phase_nxt = ph;
          unique case (ph)
            crsf_pkg::PH_SYNC: begin
              if (sync_hit) begin
                phase_nxt = crsf_pkg::PH_LEN;
              end else begin
                seen_nxt = '0; exp_nxt = '0; cnt_nxt = '0;
                err_nxt = err_sat;
                emit = 1'b1; em_status = crsf_pkg::ST_SYNC_ERR;
              end
            end
            crsf_pkg::PH_LEN: begin
              if ((b < {1'b0, cfg.length_limit}) && (b >= 8'd2)) begin
                exp_nxt   = crsf_pkg::EXP_W'(b - 8'd2);
                phase_nxt = crsf_pkg::PH_TYPE;
              end else begin
                phase_nxt = crsf_pkg::PH_SYNC;
                seen_nxt = '0; exp_nxt = '0; cnt_nxt = '0;
                err_nxt = err_sat;
                emit = 1'b1; em_status = crsf_pkg::ST_LEN_ERR;
              end
            end
            crsf_pkg::PH_TYPE: begin
              if (b < cfg.type_limit) begin
                type_nxt  = b;
                crc_nxt   = crsf_pkg::crc8_step(8'h00, b);
                phase_nxt = (exp_r == '0) ? crsf_pkg::PH_CRC : crsf_pkg::PH_PAYLOAD;
              end else begin
                phase_nxt = crsf_pkg::PH_SYNC;
                seen_nxt = '0; exp_nxt = '0; cnt_nxt = '0;
                err_nxt = err_sat;
                emit = 1'b1; em_status = crsf_pkg::ST_TYPE_ERR;
              end
            end
            crsf_pkg::PH_PAYLOAD: begin
              ram_we   = (32'(seen_r) < crsf_pkg::PAYLOAD_DEPTH);
              seen_nxt = seen_r + 1'b1;
              crc_nxt  = crsf_pkg::crc8_step(crc_r, b);
              if ((32'(seen_r) + 32'd1) >= 32'(exp_r)) begin
                phase_nxt = crsf_pkg::PH_CRC;
              end
            end
            default: begin
              phase_nxt = crsf_pkg::PH_SYNC;
              seen_nxt = '0; exp_nxt = '0; cnt_nxt = '0;
              if (b == crc_r) begin
                if (type_r == cfg.chan_type) begin
                  unp_req.start = 1'b1;
                  ctl_nxt = crsf_pkg::CTL_UNPACK;
                end else if ((type_r == crsf_pkg::LINK_STATS_TYPE) ||
                             (type_r == crsf_pkg::DEVICE_INFO_TYPE)) begin
                  emit = 1'b1; em_status = crsf_pkg::ST_OK; em_kind = type_r;
                end else begin
                  err_nxt = err_sat;
                  emit = 1'b1; em_status = crsf_pkg::ST_UNHANDLED; em_kind = type_r;
                end
              end else begin
                err_nxt = err_sat;
                emit = 1'b1; em_status = crsf_pkg::ST_CRC_ERR;
              end
            end
          endcase
        end
      end
      crsf_pkg::CTL_UNPACK: begin
        unp_ready = out_free;
        if (unp_rsp.valid && out_free && unp_rsp.last) begin
          ctl_nxt = crsf_pkg::CTL_RUN;
        end
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_kind_nxt   = out_kind_r;
    out_cvalid_nxt = out_cvalid_r;
    out_cidx_nxt   = out_cidx_r;
    out_cval_nxt   = out_cval_r;
    out_err_nxt    = out_err_r;
    out_last_nxt   = out_last_r;
    priority if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = em_status;
      out_kind_nxt   = em_kind;
      out_cvalid_nxt = 1'b0;
      out_cidx_nxt   = 4'd0;
      out_cval_nxt   = 11'd0;
      out_err_nxt    = err_nxt;
      out_last_nxt   = 1'b1;
    end else if (unp_ready && unp_rsp.valid) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = crsf_pkg::ST_OK;
      out_kind_nxt   = type_r;
      out_cvalid_nxt = 1'b1;
      out_cidx_nxt   = unp_rsp.index;
      out_cval_nxt   = unp_rsp.value;
      out_err_nxt    = err_r;
      out_last_nxt   = unp_rsp.last;
    end else if (out_bus.ready) begin
      out_valid_nxt  = 1'b0;
    end else begin
      out_valid_nxt  = out_valid_r;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.status        = out_status_r;
  assign out_bus.frame_kind    = out_kind_r;
  assign out_bus.channel_valid = out_cvalid_r;
  assign out_bus.channel_index = out_cidx_r;
  assign out_bus.channel_value = out_cval_r;
  assign out_bus.error_total   = out_err_r;
  assign out_bus.last          = out_last_r;

endmodule

@@ hdl/crsf_frame_receiver_top.sv @@
// Frame receiver top level: configuration registers, parser, payload RAM
// and channel unpacker. Depends on crsf_pkg, crsf_if and assert_macros.svh.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in_bus  | in  | valid/ready          | rx_byte
//  out_bus | out | valid/ready          | status, frame_kind, channel_*, error_total, last
//  cfg_*   | in  | cfg_we, no back-press| cfg_idx, cfg_wdata
//
// Received bytes can be taken back to back; a new byte is taken while a result
// still waits in the output register, as long as that register frees up.
// The CRC byte of a good RC-channels frame starts the unpacker, which for
// each channel issues three reads through the single RAM read port, captures
// the last read data and then presents the channel, waiting out any stall on
// out_bus, for all sixteen channels; no byte is taken meanwhile.
// rst_n is synchronous; the payload RAM needs no clearing, as bytes beyond
// the received payload are masked to zero on read.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crsf_frame_receiver_top (
  input  logic                           clk,
  input  logic                           rst_n,
  crsf_in_if.sink                        in_bus,
  crsf_out_if.source                     out_bus,
  input  logic                           cfg_we,
  input  logic [crsf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]                     cfg_wdata
);

  crsf_pkg::cfg_t cfg_r, cfg_nxt;

  logic                        ram_we;
  logic [crsf_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]                  ram_wdata, ram_rdata;
  crsf_pkg::unp_req_t          unp_req;
  crsf_pkg::unp_rsp_t          unp_rsp;
  logic                        unp_ready;

  // Register file; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        crsf_pkg::REG_SYNC_A:     cfg_nxt.sync_a       = cfg_wdata;
        crsf_pkg::REG_SYNC_B:     cfg_nxt.sync_b       = cfg_wdata;
        crsf_pkg::REG_SYNC_C:     cfg_nxt.sync_c       = cfg_wdata;
        crsf_pkg::REG_SYNC_D:     cfg_nxt.sync_d       = cfg_wdata;
        crsf_pkg::REG_LEN_LIMIT:  cfg_nxt.length_limit = cfg_wdata[6:0];
        crsf_pkg::REG_TYPE_LIMIT: cfg_nxt.type_limit   = cfg_wdata;
        crsf_pkg::REG_CHAN_TYPE:  cfg_nxt.chan_type    = cfg_wdata;
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_a       <= crsf_pkg::SYNC_A_RST;
      cfg_r.sync_b       <= crsf_pkg::SYNC_B_RST;
      cfg_r.sync_c       <= crsf_pkg::SYNC_C_RST;
      cfg_r.sync_d       <= crsf_pkg::SYNC_D_RST;
      cfg_r.length_limit <= crsf_pkg::LEN_LIMIT_RST;
      cfg_r.type_limit   <= crsf_pkg::TYPE_LIMIT_RST;
      cfg_r.chan_type    <= crsf_pkg::CHAN_TYPE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Parser writes the RAM only in the payload phase and never while the
  // unpacker reads, so no forwarding is needed.
  crsf_frame_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg       (cfg_r),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .unp_req   (unp_req),
    .unp_rsp   (unp_rsp),
    .unp_ready (unp_ready)
  );

  crsf_ram #(
    .DEPTH (crsf_pkg::PAYLOAD_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  crsf_unpack u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (unp_req),
    .rsp       (unp_rsp),
    .rsp_ready (unp_ready),
    .raddr     (ram_raddr),
    .rdata     (ram_rdata)
  );

  // Payload writes and channel reads never overlap.
  `CRSF_ASSERT(a_no_write_while_unpack, !(ram_we && unp_rsp.busy))
  // No byte is taken while channels are being unpacked.
  `CRSF_ASSERT(a_no_byte_while_unpack, !(in_bus.ready && unp_rsp.busy))
  // The unpacker only wakes up on a start request.
  `CRSF_ASSERT(a_unpack_needs_start, $rose(unp_rsp.busy) |-> $past(unp_req.start))
  // A channel result always carries the good-frame status.
  `CRSF_ASSERT(a_channel_is_ok, (out_bus.valid && out_bus.channel_valid) |-> (out_bus.status == crsf_pkg::ST_OK))

endmodule

@@ tb/crsf_frame_receiver_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for crsf_frame_receiver_top: directed rows, then random frames.
// Depends on crsf_pkg, crsf_if (in_bus/out_bus interfaces) and the receiver RTL.
module crsf_frame_receiver_top_test;
  import crsf_pkg::*;

  localparam int         CLK_HALF      = 10;
  localparam int         SETTLE_CYCLES = 20;   // ample slack for a byte that makes no result
  localparam int         DRAIN_CYCLES  = 100;  // catch stray results after the last one due
  localparam int         PHASE_BYTES   = 16;   // minimum random byte requests per register setting
  localparam int         TIMEOUT_NS    = 4_000_000;
  localparam logic [2:0] REG_SPARE     = 3'd7; // unmapped index, must be ignored

  // One result as it should appear on out_bus.
  typedef struct packed {
    status_t     status;
    logic [7:0]  kind;
    logic        chan_ok;
    logic [3:0]  chan_idx;
    logic [10:0] chan_val;
    logic [15:0] errs;
    logic        last;
  } result_t;

  // Directed rows: a literal byte, or the CRC the parser is holding (good or corrupted).
  typedef enum logic [1:0] {ROW_LIT, ROW_CRC, ROW_BAD_CRC} row_src_t;

  typedef struct packed {
    row_src_t    src;
    logic [7:0]  value;
    logic        typed;   // result written in below rather than predicted
    status_t     st;
    logic [7:0]  kind;
    logic [15:0] errs;
  } row_t;

  localparam int PLAN_ROWS = 29;

  // Runs at reset settings: syncs 238/234/200/236, length below 64, type below 125,
  // channels type 22.
  localparam row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{ROW_LIT,     8'h00,            1'b1, ST_SYNC_ERR,  8'h00,  16'd1}, // not a sync byte
    '{ROW_LIT,     8'd238,           1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'h01,            1'b1, ST_LEN_ERR,   8'h00,  16'd2}, // length below two
    '{ROW_LIT,     8'd234,           1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'd64,            1'b1, ST_LEN_ERR,   8'h00,  16'd3}, // length at limit
    '{ROW_LIT,     8'd200,           1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'd2,             1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'd125,           1'b1, ST_TYPE_ERR,  8'h00,  16'd4}, // type at limit
    '{ROW_LIT,     8'd236,           1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'd2,             1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     DEVICE_INFO_TYPE, 1'b0, ST_OK,        8'h00,  16'd0}, // empty payload
    '{ROW_CRC,     8'h00,            1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'd238,           1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'd3,             1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     LINK_STATS_TYPE,  1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'hFF,            1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_CRC,     8'h00,            1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'd234,           1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'd2,             1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'd22,            1'b0, ST_OK,        8'h00,  16'd0}, // channels, no payload
    '{ROW_CRC,     8'h00,            1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'd200,           1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'd2,             1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'd124,           1'b0, ST_OK,        8'h00,  16'd0}, // highest legal type
    '{ROW_CRC,     8'h00,            1'b1, ST_UNHANDLED, 8'd124, 16'd5},
    '{ROW_LIT,     8'd236,           1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'd2,             1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_LIT,     8'h00,            1'b0, ST_OK,        8'h00,  16'd0},
    '{ROW_BAD_CRC, 8'h00,            1'b1, ST_CRC_ERR,   8'h00,  16'd6}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [7:0]           cfg_wdata;

  crsf_in_if  in_bus ();
  crsf_out_if out_bus ();

  crsf_frame_receiver_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Bench-side copy of the register file
  // ---------------------------------------------------------------------------
  logic [7:0] cfg_sync [4];
  logic [6:0] cfg_len_limit;
  logic [7:0] cfg_type_limit;
  logic [7:0] cfg_chan_type;

  // ---------------------------------------------------------------------------
  // Parser state as the bench tracks it
  // ---------------------------------------------------------------------------
  phase_t      m_phase;
  int          m_want;         // payload bytes announced by the length byte
  int          m_got;          // payload bytes taken so far
  int          m_frame_bytes;  // bytes counted against the frame length cap
  logic [7:0]  m_type;
  logic [7:0]  m_crc;
  logic [7:0]  m_store [PAYLOAD_DEPTH];
  logic [15:0] m_errors;

  result_t results_due [$];   // predicted results, oldest first
  result_t head;

  int fail_count      = 0;
  int bytes_sent      = 0;
  int results_checked = 0;
  int channel_frames  = 0;
  int settings_used   = 0;
  int gap_rate        = 0;    // percent chance of an input gap before a byte
  int stall_left      = 0;
  bit stalls_on       = 1'b1;
  bit quiet           = 1'b0; // no idling on either side once set

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop, well past the slowest legal run (channel frames under long stalls).
  initial begin
    #(TIMEOUT_NS);
    $display("crsf_frame_receiver_top_test: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // CRC-8, poly 0xD5, MSB first, seeded by the caller.
  function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] r;
    int         k;
    r = acc ^ d;
    for (k = 0; k < 8; k++) r = (r << 1) ^ (r[7] ? CRC_POLY : 8'h00);
    return r;
  endfunction

  // Channel ch, LSB first across the stored payload; bits past the payload read 0.
  function automatic logic [10:0] channel_word(input int ch);
    logic [10:0] v;
    logic [7:0]  octet;
    int          p;
    int          k;
    v = '0;
    for (k = 0; k < CHANNEL_BITS; k++) begin
      p     = ch * CHANNEL_BITS + k;
      octet = ((p >> 3) < m_got && (p >> 3) < PAYLOAD_DEPTH) ? m_store[p >> 3] : 8'h00;
      v[k]  = octet[p & 7];
    end
    return v;
  endfunction

  function automatic result_t make_result(input status_t s, input logic [7:0] kind,
                                          input logic ok, input logic [3:0] idx,
                                          input logic [10:0] val);
    return '{s, kind, ok, idx, val, m_errors, 1'b0};
  endfunction

  task automatic clear_frame();
    m_phase       = PH_SYNC;
    m_got         = 0;
    m_want        = 0;
    m_frame_bytes = 0;
  endtask

  task automatic bump_errors();
    if (m_errors != 16'hFFFF) m_errors = m_errors + 16'd1;
  endtask

  task automatic reset_model();
    int i;
    cfg_sync[0]    = SYNC_A_RST;
    cfg_sync[1]    = SYNC_B_RST;
    cfg_sync[2]    = SYNC_C_RST;
    cfg_sync[3]    = SYNC_D_RST;
    cfg_len_limit  = LEN_LIMIT_RST;
    cfg_type_limit = TYPE_LIMIT_RST;
    cfg_chan_type  = CHAN_TYPE_RST;
    clear_frame();
    m_type   = 8'h00;
    m_crc    = 8'h00;
    m_errors = 16'h0000;
    for (i = 0; i < PAYLOAD_DEPTH; i++) m_store[i] = 8'h00;
  endtask

  // Advance the tracked parser by one accepted byte; queue its results if keep is set.
  task automatic track_byte(input logic [7:0] b, input bit keep);
    result_t batch [CHANNEL_COUNT];
    int      n;
    int      c;
    n = 0;
    // Over-long frame: drop it silently and treat this byte as a fresh sync.
    m_frame_bytes++;
    if (m_frame_bytes > FRAME_BYTE_LIMIT) clear_frame();
    case (m_phase)
      PH_SYNC: begin
        if (b == cfg_sync[0] || b == cfg_sync[1] || b == cfg_sync[2] || b == cfg_sync[3]) begin
          m_phase = PH_LEN;
        end else begin
          clear_frame();
          bump_errors();
          batch[n] = make_result(ST_SYNC_ERR, 8'h00, 1'b0, 4'd0, 11'd0);
          n = n + 1;
        end
      end
      PH_LEN: begin
        if (b < cfg_len_limit && b >= 8'd2) begin
          m_want  = b - 2;
          m_phase = PH_TYPE;
        end else begin
          bump_errors();
          clear_frame();
          batch[n] = make_result(ST_LEN_ERR, 8'h00, 1'b0, 4'd0, 11'd0);
          n = n + 1;
        end
      end
      PH_TYPE: begin
        if (b < cfg_type_limit) begin
          m_type  = b;
          m_crc   = crc_next(8'h00, b);
          m_phase = (m_want == 0) ? PH_CRC : PH_PAYLOAD;
        end else begin
          clear_frame();
          bump_errors();
          batch[n] = make_result(ST_TYPE_ERR, 8'h00, 1'b0, 4'd0, 11'd0);
          n = n + 1;
        end
      end
      PH_PAYLOAD: begin
        if (m_got < PAYLOAD_DEPTH) m_store[m_got] = b;
        m_got++;
        m_crc = crc_next(m_crc, b);
        if (m_got >= m_want) m_phase = PH_CRC;
      end
      default: begin
        if (b == m_crc) begin
          if (m_type == cfg_chan_type) begin
            channel_frames++;
            for (c = 0; c < CHANNEL_COUNT; c++) begin
              batch[n] = make_result(ST_OK, m_type, 1'b1, c[3:0], channel_word(c));
              n = n + 1;
            end
          end else if (m_type == LINK_STATS_TYPE || m_type == DEVICE_INFO_TYPE) begin
            batch[n] = make_result(ST_OK, m_type, 1'b0, 4'd0, 11'd0);
            n = n + 1;
          end else begin
            bump_errors();
            batch[n] = make_result(ST_UNHANDLED, m_type, 1'b0, 4'd0, 11'd0);
            n = n + 1;
          end
        end else begin
          bump_errors();
          batch[n] = make_result(ST_CRC_ERR, 8'h00, 1'b0, 4'd0, 11'd0);
          n = n + 1;
        end
        clear_frame();
      end
    endcase
    if (keep) begin
      for (c = 0; c < n; c++) begin
        if (c == n - 1) batch[c].last = 1'b1;
        results_due.push_back(batch[c]);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // One byte request, with an optional random gap ahead of it. valid is left
  // high on acceptance so a following byte can go out back to back.
  task automatic feed(input logic [7:0] b, input bit typed, input result_t typed_res);
    if (!quiet && gap_rate != 0 && $urandom_range(1, 100) <= gap_rate) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    track_byte(b, !typed);
    if (typed) results_due.push_back(typed_res);
    bytes_sent++;
  endtask

  // Block idle: nothing due, then SETTLE_CYCLES of slack for a byte that makes no result.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      REG_SYNC_A:     cfg_sync[0]    = v;
      REG_SYNC_B:     cfg_sync[1]    = v;
      REG_SYNC_C:     cfg_sync[2]    = v;
      REG_SYNC_D:     cfg_sync[3]    = v;
      REG_LEN_LIMIT:  cfg_len_limit  = v[6:0];
      REG_TYPE_LIMIT: cfg_type_limit = v;
      REG_CHAN_TYPE:  cfg_chan_type  = v;
      default: ;
    endcase
  endtask

  // Full register rewrite, only once the block has gone idle.
  task automatic apply_config(input logic [7:0] sa, input logic [7:0] sb,
                              input logic [7:0] sc, input logic [7:0] sd,
                              input logic [6:0] ll, input logic [7:0] tl,
                              input logic [7:0] ct);
    settle();
    write_register(REG_SYNC_A, sa);
    write_register(REG_SYNC_B, sb);
    write_register(REG_SYNC_C, sc);
    write_register(REG_SYNC_D, sd);
    write_register(REG_LEN_LIMIT, {1'b0, ll});
    write_register(REG_TYPE_LIMIT, tl);
    write_register(REG_CHAN_TYPE, ct);
    write_register(REG_SPARE, 8'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One random frame. Mostly well formed with random content; the rest are
  // frames broken at the length or type byte, and loose noise.
  task automatic gen_frame();
    logic [7:0] fr [$];
    logic [7:0] t;
    logic [7:0] crc;
    int         pick;
    int         sel;
    int         plen;
    int         max_pay;
    int         i;
    gap_rate = $urandom_range(0, 1) ? 0 : 35;
    max_pay  = cfg_len_limit - 3;
    pick     = $urandom_range(0, 99);
    if (pick < 84) fr.push_back(cfg_sync[$urandom_range(0, 3)]);
    if (pick < 62) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)       t = cfg_chan_type;
      else if (sel == 4) t = LINK_STATS_TYPE;
      else if (sel == 5) t = DEVICE_INFO_TYPE;
      else               t = 8'($urandom_range(0, cfg_type_limit - 1));
      sel = $urandom_range(0, 9);
      if (t == cfg_chan_type && sel < 6) plen = 22;        // full channels payload
      else if (sel == 9)                 plen = max_pay;   // longest allowed, may overrun cap
      else plen = $urandom_range(0, (max_pay < 6) ? max_pay : 6);
      if (plen > max_pay) plen = max_pay;
      fr.push_back(8'(plen + 2));
      fr.push_back(t);
      crc = crc_next(8'h00, t);
      for (i = 0; i < plen; i++) begin
        fr.push_back(8'($urandom_range(0, 255)));
        crc = crc_next(crc, fr[fr.size() - 1]);
      end
      if ($urandom_range(0, 9) == 0) crc = crc ^ (8'h01 << $urandom_range(0, 7));
      fr.push_back(crc);
    end else if (pick < 74) begin
      sel = $urandom_range(0, 2);
      if (sel == 0)      fr.push_back(8'h00);
      else if (sel == 1) fr.push_back(8'h01);
      else               fr.push_back(8'($urandom_range(cfg_len_limit, 255)));
    end else if (pick < 84) begin
      fr.push_back(8'($urandom_range(2, (cfg_len_limit > 8) ? 8 : cfg_len_limit - 1)));
      fr.push_back(8'($urandom_range(cfg_type_limit, 255)));
    end else begin
      repeat ($urandom_range(1, 3)) fr.push_back(8'($urandom_range(0, 255)));
    end
    for (i = 0; i < fr.size(); i++) feed(fr[i], 1'b0, '0);
  endtask

  task automatic run_random();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) gen_frame();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure bursts, switched on and off in long
  // stretches, and dropped for good once quiet is set.
  // ---------------------------------------------------------------------------
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && stalls_on && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        out_bus.ready <= 1'b1;
      end
      if ($urandom_range(0, 149) == 0) stalls_on = !stalls_on;
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Each accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (results_due.size() == 0) begin
        $error("result with nothing due: status %0d, kind %0h", out_bus.status,
               out_bus.frame_kind);
        fail_count++;
      end else begin
        head = results_due.pop_front();
        check_field("status", head.status, out_bus.status);
        check_field("frame_kind", head.kind, out_bus.frame_kind);
        check_field("channel_valid", head.chan_ok, out_bus.channel_valid);
        check_field("channel_index", head.chan_idx, out_bus.channel_index);
        check_field("channel_value", head.chan_val, out_bus.channel_value);
        check_field("error_total", head.errs, out_bus.error_total);
        check_field("last", head.last, out_bus.last);
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int         r;
    logic [7:0] b;
    logic [7:0] tl;
    result_t    typed_res;

    in_bus.valid   <= 1'b0;
    in_bus.rx_byte <= 8'h00;
    cfg_we         <= 1'b0;
    cfg_idx        <= '0;
    cfg_wdata      <= 8'h00;
    rst_n          <= 1'b0;
    reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows at reset settings; CRC rows take the CRC the parser holds.
    gap_rate = 30;
    for (r = 0; r < PLAN_ROWS; r++) begin
      case (DIRECTED_PLAN[r].src)
        ROW_CRC:     b = m_crc;
        ROW_BAD_CRC: b = ~m_crc;
        default:     b = DIRECTED_PLAN[r].value;
      endcase
      typed_res = '{DIRECTED_PLAN[r].st, DIRECTED_PLAN[r].kind, 1'b0, 4'd0, 11'd0,
                    DIRECTED_PLAN[r].errs, 1'b1};
      feed(b, DIRECTED_PLAN[r].typed, typed_res);
    end

    // Tightest limits: only length 2, type 0 gets through, and that is the
    // channels type, so every good frame unpacks to sixteen zero channels.
    apply_config(8'h00, 8'hFF, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 7'd3, 8'd1, 8'd0);
    run_random();

    // Widest limits: long frames overrun the byte cap and restart the parser.
    apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 7'd64, 8'd255, 8'd254);
    run_random();

    // Random middle ground, channels type kept below the type limit.
    tl = 8'($urandom_range(2, 255));
    apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 7'($urandom_range(3, 64)), tl, 8'($urandom_range(0, tl - 1)));
    run_random();

    // Last stretch runs without idling on either side.
    quiet = 1'b1;
    apply_config(SYNC_A_RST, SYNC_B_RST, SYNC_C_RST, SYNC_D_RST,
                 LEN_LIMIT_RST, TYPE_LIMIT_RST, CHAN_TYPE_RST);
    run_random();

    in_bus.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d byte requests under %0d register settings, %0d results checked.",
             bytes_sent, settings_used + 1, results_checked);
    $display("Good channel frames: %0d; error count at the end: %0d.",
             channel_frames, m_errors);
    if (fail_count == 0) begin
      $display("crsf_frame_receiver_top_test: done, clean");
    end else begin
      $display("crsf_frame_receiver_top_test: done, errors");
    end
    $finish;
  end

endmodule
